@@ hdl/lbp3_pkg.sv @@
// Shared types and constants for the 3x3 local binary pattern stream unit.
// No dependencies; lbp3_seq, lbp3_win and the top level refer to this package by scope.
package lbp3_pkg;

   localparam int MAX_LINE   = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIX_W      = 8;
   localparam int CFG_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int COL_W      = $clog2(MAX_LINE);
   localparam int WID_W      = $clog2(MAX_LINE + 1);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
   localparam int MIN_SIZE   = 3;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   // item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] grey_value;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pattern_code;
      logic             frame_end;
   } rsp_type;

   // control handed from the sequencer to the compute stage
   typedef struct packed {
      logic             emit;
      logic             is_pixel;
      logic             border;
      logic             last;
      logic [COL_W-1:0] col;
   } stage_ctl_type;

   typedef struct packed {
      logic             tail;
      logic [COL_W-1:0] in_col;
      logic [ROW_W-1:0] in_row;
   } seq_stat_type;

endpackage

@@ hdl/lbp3_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lbp3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lbp3_seq.sv @@
// Frame sequencer: size registers, input/output raster counters, tail state.
// Depends on lbp3_pkg.
module lbp3_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lbp3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lbp3_pkg::CFG_W-1:0]        csr_wdata,
   input  logic                              accept,
   input  logic                              kind,
   output lbp3_pkg::stage_ctl_type           ctl,
   output lbp3_pkg::seq_stat_type            stat
);

   logic [lbp3_pkg::CFG_W-1:0] frame_width_ff, frame_height_ff;
   logic [lbp3_pkg::COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [lbp3_pkg::ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic                       tail_ff, tail_in;

   logic [lbp3_pkg::WID_W-1:0] w_eff;
   logic [lbp3_pkg::HGT_W-1:0] h_eff;
   logic                       restart, is_pixel, emit, border, last;
   logic                       in_col_end, in_row_end, out_col_end, out_row_end;
   logic [lbp3_pkg::COL_W-1:0] ic, oc;
   logic [lbp3_pkg::ROW_W-1:0] ir, orw;

   // effective sizes, clamped to the supported range
   always_comb begin
      if (frame_width_ff < lbp3_pkg::CFG_W'(lbp3_pkg::MIN_SIZE)) begin
         w_eff = lbp3_pkg::WID_W'(lbp3_pkg::MIN_SIZE);
      end else if (int'(frame_width_ff) > lbp3_pkg::MAX_LINE) begin
         w_eff = lbp3_pkg::WID_W'(lbp3_pkg::MAX_LINE);
      end else begin
         w_eff = lbp3_pkg::WID_W'(frame_width_ff);
      end
      if (frame_height_ff < lbp3_pkg::CFG_W'(lbp3_pkg::MIN_SIZE)) begin
         h_eff = lbp3_pkg::HGT_W'(lbp3_pkg::MIN_SIZE);
      end else if (int'(frame_height_ff) > lbp3_pkg::MAX_HEIGHT) begin
         h_eff = lbp3_pkg::HGT_W'(lbp3_pkg::MAX_HEIGHT);
      end else begin
         h_eff = lbp3_pkg::HGT_W'(frame_height_ff);
      end
   end

   assign is_pixel = (kind == lbp3_pkg::KIND_PIXEL);
   // a pixel arriving during the tail drops the pending codes and starts a frame
   assign restart  = tail_ff && is_pixel;

   assign ic  = restart ? '0 : in_col_ff;
   assign ir  = restart ? '0 : in_row_ff;
   assign oc  = restart ? '0 : out_col_ff;
   assign orw = restart ? '0 : out_row_ff;

   assign in_col_end  = (lbp3_pkg::WID_W'(ic) + 1'b1) >= w_eff;
   assign in_row_end  = (lbp3_pkg::HGT_W'(ir) + 1'b1) >= h_eff;
   assign out_col_end = (lbp3_pkg::WID_W'(oc) + 1'b1) >= w_eff;
   assign out_row_end = (lbp3_pkg::HGT_W'(orw) + 1'b1) >= h_eff;

   // codes lag the input by one row plus one pixel
   assign emit   = is_pixel ? ((ir >= lbp3_pkg::ROW_W'(2)) ||
                               (ir == lbp3_pkg::ROW_W'(1) && ic != '0))
                            : tail_ff;
   assign border = (orw == '0) || out_row_end || (oc == '0) || out_col_end;
   assign last   = out_row_end && out_col_end;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      tail_in    = tail_ff;
      if (accept && (is_pixel || tail_ff)) begin
         out_col_in = oc;
         out_row_in = orw;
         if (emit) begin
            if (out_col_end) begin
               out_col_in = '0;
               out_row_in = orw + 1'b1;
            end else begin
               out_col_in = oc + 1'b1;
               out_row_in = orw;
            end
         end
         if (is_pixel) begin
            tail_in = 1'b0;
            if (in_col_end) begin
               in_col_in = '0;
               if (in_row_end) begin
                  in_row_in = '0;
                  tail_in   = 1'b1;
               end else begin
                  in_row_in = ir + 1'b1;
               end
            end else begin
               in_col_in = ic + 1'b1;
               in_row_in = ir;
            end
         end else if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            tail_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lbp3_pkg::WIDTH_RESET;
         frame_height_ff <= lbp3_pkg::HEIGHT_RESET;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         tail_ff         <= 1'b0;
      end else if (csr_wr_en &&
                   (csr_index == lbp3_pkg::CSR_FRAME_WIDTH ||
                    csr_index == lbp3_pkg::CSR_FRAME_HEIGHT)) begin
         if (csr_index == lbp3_pkg::CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata;
         end else begin
            frame_height_ff <= csr_wdata;
         end
         // a size change restarts the frame; line stores are kept
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         tail_ff    <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         tail_ff    <= tail_in;
      end
   end

   assign ctl.emit     = emit;
   assign ctl.is_pixel = is_pixel;
   assign ctl.border   = border;
   assign ctl.last     = last;
   assign ctl.col      = ic;

   assign stat.tail   = tail_ff;
   assign stat.in_col = in_col_ff;
   assign stat.in_row = in_row_ff;

endmodule

@@ hdl/lbp3_win.sv @@
// 3x3 window shift registers and the eight strict-greater compares.
// Depends on lbp3_pkg.
module lbp3_win (
   input  logic                       clock,
   input  logic                       shift,
   input  logic [lbp3_pkg::PIX_W-1:0] top_pix,
   input  logic [lbp3_pkg::PIX_W-1:0] mid_pix,
   input  logic [lbp3_pkg::PIX_W-1:0] bot_pix,
   output logic [lbp3_pkg::PIX_W-1:0] code
);

   // 0..2: column two back (top, mid, bottom), 3..5: previous column
   logic [lbp3_pkg::PIX_W-1:0] win_ff [6];
   logic [lbp3_pkg::PIX_W-1:0] ctr;

   assign ctr = win_ff[4];

   always_comb begin
      code[0] = win_ff[0] > ctr;
      code[1] = win_ff[3] > ctr;
      code[2] = top_pix   > ctr;
      code[3] = win_ff[1] > ctr;
      code[4] = mid_pix   > ctr;
      code[5] = win_ff[2] > ctr;
      code[6] = win_ff[5] > ctr;
      code[7] = bot_pix   > ctr;
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_pix;
         win_ff[4] <= mid_pix;
         win_ff[5] <= bot_pix;
      end
   end

endmodule

@@ hdl/lbp_3x3_code_stream_unit.sv @@
// Top level of the 3x3 local binary pattern stream unit.
// Depends on lbp3_pkg, lbp3_ram, lbp3_seq and lbp3_win.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    lbp3_pkg::req_type (kind, grey_value)
//   rsp      out        rsp_valid/ready    lbp3_pkg::rsp_type (pattern_code, frame_end)
//   csr      in         csr_wr_en          csr_index, csr_wdata (no read-back)
//
// One item per clock sustained while the output does not stall. An item is taken in
// and reads the two-line store (one 16-bit RAM, registered read); the compute stage
// then forms its code, writes the store back and loads the output register.
// Reset brings the sizes to 640x480 and restarts the frame; line contents are
// not cleared: entries not yet written in a frame feed only border codes,
// which are forced to zero.
// A stalled output holds the compute stage; req_ready drops only then.
module lbp_3x3_code_stream_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lbp3_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lbp3_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [lbp3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbp3_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int PW = lbp3_pkg::PIX_W;

   lbp3_pkg::stage_ctl_type ctl, s1_ctl_ff;
   lbp3_pkg::seq_stat_type  stat;
   lbp3_pkg::rsp_type       rsp_ff, rsp_in;
   logic [PW-1:0]           s1_pix_ff;
   logic                    s1_valid_ff, s1_valid_in, rsp_valid_ff, rsp_valid_in;
   logic                    accept, s1_load, s1_adv, out_free;
   logic [2*PW-1:0]         rd_data;
   logic [PW-1:0]           code;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_adv   = s1_valid_ff && (!s1_ctl_ff.emit || out_free);
   assign req_ready = !s1_valid_ff || s1_adv;
   // an ignored flush never enters the compute stage
   assign s1_load  = accept && (ctl.is_pixel || ctl.emit);

   lbp3_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .kind      (req_data.kind),
      .ctl       (ctl),
      .stat      (stat)
   );

   // upper line in the high byte, middle line in the low byte
   lbp3_ram #(
      .WIDTH (2 * PW),
      .DEPTH (lbp3_pkg::MAX_LINE)
   ) u_lines (
      .clock   (clock),
      .wr_en   (s1_adv && s1_ctl_ff.is_pixel),
      .wr_addr (s1_ctl_ff.col),
      .wr_data ({rd_data[PW-1:0], s1_pix_ff}),
      .rd_en   (accept),
      .rd_addr (ctl.col),
      .rd_data (rd_data)
   );

   lbp3_win u_win (
      .clock   (clock),
      .shift   (s1_adv && s1_ctl_ff.is_pixel),
      .top_pix (rd_data[2*PW-1:PW]),
      .mid_pix (rd_data[PW-1:0]),
      .bot_pix (s1_pix_ff),
      .code    (code)
   );

   always_comb begin
      s1_valid_in = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_in.pattern_code = (s1_ctl_ff.border || !s1_ctl_ff.is_pixel) ? '0 : code;
      rsp_in.frame_end    = s1_ctl_ff.last;
      if (s1_adv && s1_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_load) begin
         s1_ctl_ff <= ctl;
         s1_pix_ff <= req_data.grey_value;
      end
      if (s1_adv && s1_ctl_ff.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the last code of a frame is a corner, so always zero
   a_frame_end_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.pattern_code == '0)
      else $error("frame_end item carries a nonzero code");

   // a full compute stage behind a stalled output must block the input
   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ctl_ff.emit && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while compute stage is stalled");

   // while the tail drains, the input position sits at the start of a frame
   a_tail_at_origin : assert property (@(posedge clock) disable iff (reset)
      stat.tail |-> stat.in_col == '0 && stat.in_row == '0)
      else $error("tail pending with input position off the frame origin");

   // an ignored flush leaves nothing behind in the compute stage
   a_flush_ignored : assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == lbp3_pkg::KIND_FLUSH && !stat.tail
      && !s1_valid_ff |=> !s1_valid_ff)
      else $error("ignored flush entered the compute stage");

endmodule
